FILE: rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants, types and helpers of the signed integer to text block.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DEPTH       = VALUE_WIDTH;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [5:0] DIGIT_NINE = 6'd9;
  localparam logic [5:0] DIGIT_TEN  = 6'd10;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [5:0]             digit_t;
  typedef logic [6:0]             char_t;

  function automatic char_t digit_char(digit_t d);
    if (d > DIGIT_NINE) begin
      return CHAR_A + {1'b0, d - DIGIT_TEN};
    end
    return CHAR_ZERO + {1'b0, d};
  endfunction

  function automatic digit_t clamp_radix(logic [5:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/sitoa_if.sv
// ----------------------------------------------------------------------------
// sitoa_in_if / sitoa_out_if
// Valid/ready channels for the input numbers and the output characters.
// ----------------------------------------------------------------------------
interface sitoa_in_if import sitoa_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if import sitoa_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: rtl/signed_int_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_ascii_radix_top
// Signed integer to ASCII text in a programmable base, 2 to 36.
//
// in_ch carries one signed number per beat; out_ch returns its text one
// character per beat, most significant first, '-' ahead of negative values,
// last set on the final character. cfg_we/cfg_wdata write the radix; out
// of range values saturate to 2 or 36. Reset sets the radix to 10 and
// empties the block.
// Each digit comes from a bit-serial restoring division of the magnitude by
// the radix, one quotient bit per cycle. Digits go onto a small stack and are
// read back in reverse, through a fetch state and a load state per character.
// in_ch.ready is high only while no number is in work. A single output
// register holds the current character; when the receiver stalls, the
// character waits there and conversion of the rest halts.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_radix_top import sitoa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sitoa_in_if.sink           in_ch,
  sitoa_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [5:0]       radix_r;
  digit_t           div_r;
  logic             neg_r;
  value_t           mag_r, mag_nxt;
  digit_t           rem_r, rem_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [CNT_W-1:0] ndig_r, ndig_nxt;
  digit_t           mem [DEPTH];
  digit_t           rd_data_r;
  logic             out_valid_r;
  char_t            out_char_r;
  logic             out_last_r;

  logic             accept;
  logic             out_load;
  logic [6:0]       trial;
  logic             qbit;
  digit_t           rem_div;
  logic             push;
  logic [IDX_W-1:0] rd_idx;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_load = !out_valid_r || out_ch.ready;
  assign trial    = {rem_r, mag_r[VALUE_WIDTH-1]};
  assign qbit     = trial >= {1'b0, div_r};
  assign rem_div  = qbit ? 6'(trial - {1'b0, div_r}) : trial[5:0];
  assign push     = (state_r == ST_DIV) && (bit_r == BIT_W'(VALUE_WIDTH - 1));
  assign rd_idx   = IDX_W'(ndig_r - CNT_W'(1));

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    ndig_nxt  = ndig_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_nxt   = in_ch.value[VALUE_WIDTH-1] ? (~in_ch.value + value_t'(1)) : in_ch.value;
          rem_nxt   = '0;
          bit_nxt   = '0;
          ndig_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_div;
        mag_nxt = {mag_r[VALUE_WIDTH-2:0], qbit};
        bit_nxt = bit_r + BIT_W'(1);
        if (push) begin
          ndig_nxt = ndig_r + CNT_W'(1);
          rem_nxt  = '0;
          bit_nxt  = '0;
          if (mag_nxt == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_FETCH;
          end
        end
      end
      ST_SIGN: begin
        if (out_load) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_load) begin
          ndig_nxt  = ndig_r - CNT_W'(1);
          state_nxt = (ndig_r == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
      ndig_r      <= '0;
      bit_r       <= '0;
    end else begin
      state_r <= state_nxt;
      ndig_r  <= ndig_nxt;
      bit_r   <= bit_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (state_r == ST_SIGN && out_load) begin
        out_valid_r <= 1'b1;
      end else if (state_r == ST_DIGIT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    if (accept) begin
      neg_r <= in_ch.value[VALUE_WIDTH-1];
      div_r <= clamp_radix(radix_r);
    end
    if (push) begin
      mem[ndig_r[IDX_W-1:0]] <= rem_div;
    end
    rd_data_r <= mem[rd_idx];
    if (state_r == ST_SIGN && out_load) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (state_r == ST_DIGIT && out_load) begin
      out_char_r <= digit_char(rd_data_r);
      out_last_r <= (ndig_r == CNT_W'(1));
    end
  end

endmodule

FILE: rtl/sitoa_chk.sv
// ----------------------------------------------------------------------------
// sitoa_chk
// Port-level checks of the signed integer to text block, bound to the top.
// ----------------------------------------------------------------------------
module sitoa_chk import sitoa_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input char_t out_char,
  input logic  out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
    else $error("stalled output beat changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a number is in work");

  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char == CHAR_MINUS) ||
                  (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 7'd9) ||
                  (out_char >= CHAR_A && out_char <= CHAR_A + 7'd25))
    else $error("illegal output character");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char != CHAR_MINUS)
    else $error("sign marked as last character");

endmodule

bind signed_int_to_ascii_radix_top sitoa_chk u_sitoa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_code),
  .out_last  (out_ch.last)
);
